[rtl/apr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants for the aging page replacer.
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam int AGE_W        = 8;
    localparam int PAGE_IDX_W   = 3;
    localparam int FRAME_W      = 4;
    localparam int COUNT_W      = 4;
    localparam int REF_W        = 8;

    localparam int DEF_NUM_PAGES  = 8;
    localparam int DEF_NUM_FRAMES = 16;

    localparam logic [COUNT_W-1:0] WSL_RESET = 4'd4;

    localparam logic MODE_ACCESS = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [PAGE_IDX_W-1:0] page_index;
        logic [REF_W-1:0]      ref_bits;
    } in_item_t;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_W-1:0]    frame_number;
        logic                  evicted;
        logic [PAGE_IDX_W-1:0] evicted_page;
    } out_item_t;

endpackage
`default_nettype wire

[rtl/aging_page_replacer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aging_page_replacer_core
// Aging page replacement over a small set of pages sharing a pool of frames.
// ----------------------------------------------------------------------------
// Takes one item per clock unless stalled: an aging tick (no result) or a page
// access (one result: hit, frame, and the evicted page if any). An item waits
// in the input register, where the search for the resident page with the
// smallest aging counter, the state update and the result are done in one pass
// into the result register. The input register is refilled in the same cycle
// it is consumed, so the block keeps one item per cycle as long as results are
// taken. A stalled result holds back only accesses; ticks still pass. The user
// must write working_set_limit through cfg_wr_en/cfg_wr_data only while the
// block is idle; the block does not enforce it. It resets to 4.
module aging_page_replacer_core
    import apr_pkg::*;
#(
    parameter int NUM_PAGES  = DEF_NUM_PAGES,
    parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_data,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_data
);

    localparam logic [COUNT_W-1:0]  PAGES_LIM  = COUNT_W'(NUM_PAGES);
    localparam logic [FRAME_W:0]    FRAMES_LIM = (FRAME_W+1)'(NUM_FRAMES);

    logic [COUNT_W-1:0]    wsl_reg;

    logic                  in_valid_reg;
    in_item_t              in_reg;

    logic [AGE_W-1:0]      age_reg      [NUM_PAGES];
    logic [AGE_W-1:0]      age_next     [NUM_PAGES];
    logic [NUM_PAGES-1:0]  resident_reg;
    logic [NUM_PAGES-1:0]  resident_next;
    logic [FRAME_W-1:0]    frame_reg    [NUM_PAGES];
    logic [FRAME_W-1:0]    frame_next   [NUM_PAGES];
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [FRAME_W-1:0]    free_reg;
    logic [FRAME_W-1:0]    free_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_item_t             out_reg;
    out_item_t             out_next;

    logic                  idx_ok;
    logic                  produces;
    logic                  proc_en;

    assign idx_ok   = {1'b0, in_reg.page_index} < PAGES_LIM;
    assign produces = (in_reg.mode == MODE_ACCESS) && idx_ok;
    assign proc_en  = in_valid_reg && (!produces || !out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || proc_en;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        logic [AGE_W:0]        best;
        logic [PAGE_IDX_W-1:0] victim;
        logic                  evict;
        logic [FRAME_W-1:0]    frame;
        logic [FRAME_W:0]      free_inc;

        age_next      = age_reg;
        resident_next = resident_reg;
        frame_next    = frame_reg;
        count_next    = count_reg;
        free_next     = free_reg;
        out_next      = out_reg;
        best          = {1'b1, {AGE_W{1'b0}}};
        victim        = '0;
        evict         = 1'b0;
        frame         = free_reg;
        free_inc      = {1'b0, free_reg} + 1'b1;

        // smallest counter among resident pages, ties to the lowest index
        for (int i = 0; i < NUM_PAGES; i++) begin
            if (resident_reg[i] && ({1'b0, age_reg[i]} < best)) begin
                best   = {1'b0, age_reg[i]};
                victim = PAGE_IDX_W'(i);
                evict  = 1'b1;
            end
        end
        if (count_reg < wsl_reg) begin
            evict = 1'b0;
        end
        if (evict) begin
            frame = frame_reg[victim];
        end

        if (in_reg.mode == MODE_TICK) begin
            for (int i = 0; i < NUM_PAGES; i++) begin
                age_next[i] = {in_reg.ref_bits[REF_W-1-i], age_reg[i][AGE_W-1:1]};
            end
        end else if (idx_ok) begin
            if (resident_reg[in_reg.page_index]) begin
                out_next.hit          = 1'b1;
                out_next.frame_number = frame_reg[in_reg.page_index];
                out_next.evicted      = 1'b0;
                out_next.evicted_page = '0;
            end else begin
                if (evict) begin
                    resident_next[victim] = 1'b0;
                    age_next[victim]      = '0;
                end else begin
                    free_next = (free_inc >= FRAMES_LIM) ? '0 : free_inc[FRAME_W-1:0];
                    if (count_reg != {COUNT_W{1'b1}}) begin
                        count_next = count_reg + 1'b1;
                    end
                end
                frame_next[in_reg.page_index]    = frame;
                resident_next[in_reg.page_index] = 1'b1;
                out_next.hit          = 1'b0;
                out_next.frame_number = frame;
                out_next.evicted      = evict;
                out_next.evicted_page = evict ? victim : '0;
            end
        end
    end

    always_comb begin
        if (proc_en && produces) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsl_reg       <= WSL_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            resident_reg  <= '0;
            count_reg     <= '0;
            free_reg      <= '0;
            for (int i = 0; i < NUM_PAGES; i++) begin
                age_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                wsl_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
            if (proc_en) begin
                resident_reg <= resident_next;
                count_reg    <= count_next;
                free_reg     <= free_next;
                age_reg      <= age_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (proc_en) begin
            frame_reg <= frame_next;
        end
        if (proc_en && produces) begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

[tb/tb_aging_page_replacer_core.sv]
// ----------------------------------------------------------------------------
// tb_aging_page_replacer_core
// Self-checking bench for the aging page replacer core. A scoreboard class
// keeps its own copy of the page table and the working-set limit. It predicts
// the result of every accepted access and compares each result transfer with
// the oldest prediction. Directed items first, then random phases, each with
// its own limit and its own sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_aging_page_replacer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import apr_pkg::*;

    localparam int NPAGES = DEF_NUM_PAGES;
    localparam int NFRAMES = DEF_NUM_FRAMES;
    localparam int PHASE_ITEMS = 156;
    localparam int HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES = 8;

    class page_scoreboard;
        logic [AGE_W-1:0]   age[NPAGES];
        bit                 resident[NPAGES];
        logic [FRAME_W-1:0] frame_of[NPAGES];
        logic [COUNT_W-1:0] placed_count;
        logic [FRAME_W-1:0] next_frame;
        logic [COUNT_W-1:0] ws_limit;
        out_item_t          expected_q[$];
        int                 errors;

        function new();
            for (int i = 0; i < NPAGES; i++) begin
                age[i] = '0;
                resident[i] = 0;
                frame_of[i] = '0;
            end
            placed_count = '0;
            next_frame = '0;
            ws_limit = WSL_RESET;
            errors = 0;
        endfunction

        function void set_limit(logic [COUNT_W-1:0] v);
            ws_limit = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(in_item_t it);
            out_item_t          res;
            bit                 evict;
            int                 victim;
            int                 best;
            int                 pg;
            logic [FRAME_W-1:0] fr;
            evict = 0;
            victim = 0;
            best = 256;
            pg = it.page_index;
            if (it.mode == MODE_TICK) begin
                for (int i = 0; i < NPAGES; i++)
                    age[i] = {it.ref_bits[7-i], age[i][AGE_W-1:1]};
                return;
            end
            if (pg >= NPAGES)
                return;
            res = '0;
            if (resident[pg]) begin
                res.hit = 1'b1;
                res.frame_number = frame_of[pg];
                expected_q.push_back(res);
                return;
            end
            if (placed_count >= ws_limit) begin
                // strict less-than keeps the lowest index on ties
                for (int i = 0; i < NPAGES; i++) begin
                    if (resident[i] && int'(age[i]) < best) begin
                        best = age[i];
                        victim = i;
                        evict = 1;
                    end
                end
            end
            if (evict) begin
                fr = frame_of[victim];
                resident[victim] = 0;
                age[victim] = '0;
            end else begin
                // no victim or below the limit: take the next free frame
                fr = next_frame;
                next_frame = (int'(next_frame) + 1 >= NFRAMES) ? '0 : next_frame + 1'b1;
                if (placed_count < 4'd15)
                    placed_count = placed_count + 1'b1;
            end
            frame_of[pg] = fr;
            resident[pg] = 1;
            res.frame_number = fr;
            res.evicted = evict;
            res.evicted_page = evict ? PAGE_IDX_W'(victim) : '0;
            expected_q.push_back(res);
        endfunction

        function void report_field(string name, int exp_v, int act_v);
            $display("[%0t] mismatch on %s: expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            errors++;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                $display("[%0t] unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.hit !== want.hit)
                report_field("hit", want.hit, got.hit);
            if (got.frame_number !== want.frame_number)
                report_field("frame_number", want.frame_number, got.frame_number);
            if (got.evicted !== want.evicted)
                report_field("evicted", want.evicted, got.evicted);
            if (got.evicted_page !== want.evicted_page)
                report_field("evicted_page", want.evicted_page, got.evicted_page);
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;

    page_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    aging_page_replacer_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("** aging_page_replacer_core: FAILED **");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off counted here
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input(s_data);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    task automatic send_item(in_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic write_limit(logic [COUNT_W-1:0] v);
        drop_valid();
        wait_drain();
        // ticks leave no result, so let the pipeline empty
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        sb.set_limit(v);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_access(int pg);
        in_item_t it;
        it.mode = MODE_ACCESS;
        it.page_index = PAGE_IDX_W'(pg);
        it.ref_bits = REF_W'($urandom);
        send_item(it);
    endtask

    task automatic send_tick(logic [REF_W-1:0] refs);
        in_item_t it;
        it.mode = MODE_TICK;
        it.page_index = PAGE_IDX_W'($urandom);
        it.ref_bits = refs;
        send_item(it);
    endtask

    function automatic in_item_t random_item(bit access_only);
        in_item_t it;
        int       pick;
        pick = $urandom_range(9);
        it.mode = (!access_only && $urandom_range(99) < 25) ? MODE_TICK : MODE_ACCESS;
        it.page_index = PAGE_IDX_W'($urandom_range(NPAGES - 1));
        if (pick == 0)
            it.ref_bits = '0;
        else if (pick == 1)
            it.ref_bits = '1;
        else
            it.ref_bits = REF_W'($urandom);
        return it;
    endfunction

    task automatic run_phase(int idle, int stall, logic [COUNT_W-1:0] lim,
                             bit hold, bit pause);
        write_limit(lim);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (hold && k == 10)
                hold_left = HOLD_CYCLES;
            if (pause && k == PHASE_ITEMS / 2) begin
                drop_valid();
                wait_drain();
            end
            send_item(random_item(hold && k >= 10 && k < 60));
        end
        drop_valid();
    endtask

    initial begin
        logic [COUNT_W-1:0] limits[8];
        int                 idles[4];
        int                 stalls[4];
        sb = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // limit of zero: first miss finds no victim, the next one evicts
        write_limit(4'd0);
        send_access(3);
        send_access(3);
        send_access(5);
        // limit above the page count: misses only take free frames
        write_limit(4'd15);
        send_access(0);
        send_access(7);
        send_access(2);
        repeat (8) send_tick(8'hFF);
        // every counter saturated, victim picked among 0xFF counters
        write_limit(4'd4);
        send_access(6);
        send_tick(8'h00);
        send_tick(8'h01);
        send_access(1);
        write_limit(4'd8);
        send_access(4);
        send_access(4);

        // low limits first: residents never shrink, so keep misses possible
        limits = '{4'd1, 4'd3, 4'd5, 4'd2, 4'd6, 4'd0, 4'd7, 4'd15};
        limits[5] = COUNT_W'($urandom_range(5, 1));
        idles = '{0, 76, 0, 26};
        stalls = '{0, 0, 76, 26};
        for (int p = 0; p < 8; p++)
            run_phase(idles[p % 4], stalls[p % 4], limits[p], p == 4, p == 5);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** aging_page_replacer_core: PASSED **");
        end else begin
            $display("** aging_page_replacer_core: FAILED **");
        end
        $finish;
    end

endmodule
